// ===== rtl/core/ffa_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// Segment record, cell command broadcast and status codes.
// No dependencies.
package ffa_pkg;

	localparam int HEAP_BYTES   = 1048576;
	localparam int HEADER_BYTES = 12;
	localparam int MAX_SEGMENTS = 64;

	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	// rounded request can reach one past the largest size
	localparam int NEED_W = SIZE_W + 1;
	localparam int SUM_W  = NEED_W + 1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FAIL    = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SPLIT,
		CMD_TAKE,
		CMD_FREE,
		CMD_MERGE_R,
		CMD_MERGE_L
	} cell_cmd_t;

	typedef struct packed {
		logic              valid;
		logic              free;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} seg_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic              op;
		logic [NEED_W-1:0] need;
		logic [ADDR_W-1:0] addr;
	} cell_ctl_t;

	localparam seg_t SEG_HEAD = '{
		valid: 1'b1,
		free:  1'b1,
		start: '0,
		size:  SIZE_W'(HEAP_BYTES - HEADER_BYTES)
	};

endpackage

// ===== rtl/core/ffa_cell.sv =====
// One segment cell of the allocator chain.
// Holds one segment record, matches it against the broadcast request and
// moves records to and from its neighbors. Uses ffa_pkg.
module ffa_cell import ffa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seg_t      rst_seg,
	input  cell_ctl_t ctl,
	input  logic      sel,
	input  logic      sel_left,
	input  logic      sel_right,
	input  logic      after,
	input  seg_t      left,
	input  seg_t      right,
	output seg_t      seg,
	output logic      hit
);

	seg_t seg_q;

	logic [SIZE_W:0] addr_cmp;

	assign addr_cmp = {1'b0, seg_q.start} + (SIZE_W+1)'(HEADER_BYTES);

	always_comb begin
		if (ctl.op) begin
			hit = seg_q.valid && (addr_cmp == {2'b0, ctl.addr});
		end else begin
			hit = seg_q.valid && seg_q.free && ({1'b0, seg_q.size} >= ctl.need);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= rst_seg;
		end else begin
			case (ctl.cmd)
				CMD_SPLIT: begin
					if (sel) begin
						seg_q.size <= ctl.need[SIZE_W-1:0];
						seg_q.free <= 1'b0;
					end else if (sel_left) begin
						// remainder of the left neighbor becomes a new free segment
						seg_q.valid <= 1'b1;
						seg_q.free  <= 1'b1;
						seg_q.start <= left.start + ADDR_W'(HEADER_BYTES)
							+ ctl.need[ADDR_W-1:0];
						seg_q.size  <= left.size - ctl.need[SIZE_W-1:0]
							- SIZE_W'(HEADER_BYTES);
					end else if (after) begin
						seg_q <= left;
					end
				end
				CMD_TAKE: begin
					if (sel) begin
						seg_q.free <= 1'b0;
					end
				end
				CMD_FREE: begin
					if (sel) begin
						seg_q.free <= 1'b1;
					end
				end
				CMD_MERGE_R: begin
					if (sel) begin
						seg_q.free <= 1'b1;
						seg_q.size <= seg_q.size + SIZE_W'(HEADER_BYTES) + right.size;
					end else if (after) begin
						seg_q <= right;
					end
				end
				CMD_MERGE_L: begin
					if (sel_right) begin
						seg_q.size <= seg_q.size + SIZE_W'(HEADER_BYTES) + right.size;
					end else if (sel || after) begin
						seg_q <= right;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign seg = seg_q;

endmodule

// ===== rtl/core/ffa_chain.sv =====
// Row of segment cells in address order, with neighbor wiring.
// Ends of the row see an empty segment. Uses ffa_pkg and ffa_cell.
module ffa_chain import ffa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctl_t                     ctl,
	input  logic [MAX_SEGMENTS-1:0]       sel,
	input  logic [MAX_SEGMENTS-1:0]       after,
	output logic [MAX_SEGMENTS-1:0]       hit,
	output seg_t [MAX_SEGMENTS-1:0]       segs
);

	seg_t [MAX_SEGMENTS+1:0] seg_ext;
	logic [MAX_SEGMENTS+1:0] sel_ext;

	assign seg_ext[0]              = '0;
	assign seg_ext[MAX_SEGMENTS+1] = '0;
	assign sel_ext                 = {1'b0, sel, 1'b0};

	for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
		assign seg_ext[k+1] = segs[k];

		ffa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.rst_seg   ((k == 0) ? SEG_HEAD : '0),
			.ctl       (ctl),
			.sel       (sel[k]),
			.sel_left  (sel_ext[k]),
			.sel_right (sel_ext[k+2]),
			.after     (after[k]),
			.left      (seg_ext[k]),
			.right     (seg_ext[k+2]),
			.seg       (segs[k]),
			.hit       (hit[k])
		);
	end

endmodule

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator with coalescing: sequencer over a chain of segment cells.
// Allocate: search, first-match pick, gather and one chain update step (split or take), then the result.
// Free: search, pick, gather, right merge step and left merge step; an unknown address skips the left step.
// A result held by out_stall delays the next one. One item at a time; a new item is taken only
// once the result of the last one has been moved to the output register.
// Reset (async, active low) leaves one free segment spanning the heap and no result pending.
module first_fit_heap_allocator_core import ffa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [SIZE_W-1:0] req_size,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] payload_addr,
	output logic [1:0]        status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_PICK,
		S_GATHER,
		S_ALLOC,
		S_FREE_R,
		S_FREE_L,
		S_DONE
	} state_t;

	state_t state_q;

	logic              op_q;
	logic              zero_q;
	logic [NEED_W-1:0] need_q;
	logic [ADDR_W-1:0] addr_q;

	logic [MAX_SEGMENTS-1:0] hit_q;
	logic [MAX_SEGMENTS-1:0] sel_q;
	logic [MAX_SEGMENTS-1:0] after_q;
	logic                    found_q;
	logic [ADDR_W-1:0]       sel_start_q;
	logic [SIZE_W-1:0]       sel_size_q;
	logic                    lfree_q;
	logic                    rfree_q;

	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_status_q;

	cell_ctl_t               ctl;
	logic [MAX_SEGMENTS-1:0] hit;
	seg_t [MAX_SEGMENTS-1:0] segs;

	logic [MAX_SEGMENTS-1:0] free_v;
	logic [MAX_SEGMENTS-1:0] valid_v;
	logic [ADDR_W-1:0]       g_start;
	logic [SIZE_W-1:0]       g_size;
	logic                    split;

	ffa_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sel    (sel_q),
		.after  (after_q),
		.hit    (hit),
		.segs   (segs)
	);

	// onehot gather of the picked segment
	always_comb begin
		g_start = '0;
		g_size  = '0;
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			free_v[k]  = segs[k].free;
			valid_v[k] = segs[k].valid;
			g_start    = g_start | (segs[k].start & {ADDR_W{sel_q[k]}});
			g_size     = g_size | (segs[k].size & {SIZE_W{sel_q[k]}});
		end
	end

	assign split = ({2'b0, sel_size_q} > ({1'b0, need_q} + SUM_W'(HEADER_BYTES)))
		&& !segs[MAX_SEGMENTS-1].valid;

	always_comb begin
		ctl.op   = op_q;
		ctl.need = need_q;
		ctl.addr = addr_q;
		ctl.cmd  = CMD_NONE;
		case (state_q)
			S_ALLOC: begin
				if (found_q && !zero_q) begin
					ctl.cmd = split ? CMD_SPLIT : CMD_TAKE;
				end
			end
			S_FREE_R: begin
				if (found_q) begin
					ctl.cmd = rfree_q ? CMD_MERGE_R : CMD_FREE;
				end
			end
			S_FREE_L: begin
				if (lfree_q) begin
					ctl.cmd = CMD_MERGE_L;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= 1'b0;
			zero_q       <= 1'b0;
			need_q       <= '0;
			addr_q       <= '0;
			hit_q        <= '0;
			sel_q        <= '0;
			after_q      <= '0;
			found_q      <= 1'b0;
			sel_start_q  <= '0;
			sel_size_q   <= '0;
			lfree_q      <= 1'b0;
			rfree_q      <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						zero_q  <= (req_size == '0);
						need_q  <= ({1'b0, req_size} + NEED_W'(3)) & ~NEED_W'(3);
						addr_q  <= address;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					hit_q   <= hit;
					state_q <= S_PICK;
				end
				S_PICK: begin
					// lowest set bit: first fit in address order
					sel_q   <= hit_q & (~hit_q + MAX_SEGMENTS'(1));
					found_q <= |hit_q;
					state_q <= S_GATHER;
				end
				S_GATHER: begin
					after_q     <= ~((sel_q - MAX_SEGMENTS'(1)) | sel_q);
					sel_start_q <= g_start;
					sel_size_q  <= g_size;
					lfree_q     <= |(sel_q[MAX_SEGMENTS-1:1] & free_v[MAX_SEGMENTS-2:0]);
					rfree_q     <= |(sel_q[MAX_SEGMENTS-2:0] & free_v[MAX_SEGMENTS-1:1]
						& valid_v[MAX_SEGMENTS-1:1]);
					state_q     <= op_q ? S_FREE_R : S_ALLOC;
				end
				S_ALLOC: begin
					if (found_q && !zero_q) begin
						res_addr_q   <= sel_start_q + ADDR_W'(HEADER_BYTES);
						res_status_q <= ST_OK;
					end else begin
						res_addr_q   <= '0;
						res_status_q <= ST_FAIL;
					end
					state_q <= S_DONE;
				end
				S_FREE_R: begin
					res_addr_q <= '0;
					if (found_q) begin
						res_status_q <= ST_OK;
						state_q      <= S_FREE_L;
					end else begin
						res_status_q <= ST_UNKNOWN;
						state_q      <= S_DONE;
					end
				end
				S_FREE_L: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign payload_addr = out_addr_q;
	assign status       = out_status_q;

endmodule

// ===== rtl/core/ffa_checker.sv =====
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Uses ffa_pkg for the status codes.
module ffa_checker import ffa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              op,
	input logic [SIZE_W-1:0] req_size,
	input logic [ADDR_W-1:0] address,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ADDR_W-1:0] payload_addr,
	input logic [1:0]        status
);

	// one item in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted a new item while one was in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FAIL || status == ST_UNKNOWN))
		else $error("status code out of range");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (payload_addr == '0))
		else $error("failed item carries a nonzero address");

	// segment starts stay 4-byte aligned, so payloads do too
	a_addr_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (payload_addr[1:0] == 2'b00))
		else $error("payload address not aligned");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(payload_addr) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator_core ffa_checker u_ffa_checker (.*);
